// ===== hdl/rcmp_pkg.sv =====
// Shared types and constants of the RFB client message parser.
// Holds the parser phases, the queue item between front and back, and the result layout.
// No dependencies.
package rcmp_pkg;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_PAD    = 3'd1,
    PH_PIXEL  = 3'd2,
    PH_COUNT  = 3'd3,
    PH_ENC    = 3'd4,
    PH_UPDATE = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    OP_PIX     = 3'd0,
    OP_UPD     = 3'd1,
    OP_ENC     = 3'd2,
    OP_EMPTY   = 3'd3,
    OP_UNKNOWN = 3'd4,
    OP_UNSUP   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    KIND_PIXEL_FORMAT = 3'd0,
    KIND_ENCODING     = 3'd1,
    KIND_EMPTY_ENC    = 3'd2,
    KIND_UPDATE_REQ   = 3'd3,
    KIND_UNKNOWN      = 3'd4,
    KIND_UNSUPPORTED  = 3'd5
  } kind_e;

  localparam logic [7:0] MT_PIXEL_FORMAT = 8'd0;
  localparam logic [7:0] MT_SET_ENC      = 8'd2;
  localparam logic [7:0] MT_UPDATE_REQ   = 8'd3;
  localparam logic [7:0] MT_UNSUP_LO     = 8'd4;
  localparam logic [7:0] MT_UNSUP_HI     = 8'd6;

  localparam logic [3:0] PIX_PAD_LAST  = 4'd2;
  localparam logic [3:0] ENC_PAD_LAST  = 4'd0;
  localparam logic [3:0] PIX_BODY_LAST = 4'd15;
  localparam logic [3:0] UPD_BODY_LAST = 4'd8;
  localparam logic [3:0] ENC_ID_LAST   = 4'd3;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    op_e        code;
    logic [3:0] pos;
    logic       last;
    logic       eom;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    kind_e       kind;
    logic        eom;
    logic [7:0]  small_a;
    logic [7:0]  small_b;
    logic [7:0]  big_endian_flag;
    logic [7:0]  true_colour_flag;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [23:0] shift_triplet;
    logic [31:0] encoding_id;
  } result_t;

endpackage

// ===== hdl/rcmp_front.sv =====
// Front end of the parser: tracks the message phase and turns bytes into queue items.
// Padding, valid type bytes, nonzero counts and bytes after an error produce no item.
// Depends on rcmp_pkg.
module rcmp_front import rcmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output logic       push_o,
  output op_t        op_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic        is_pix_q, is_pix_d;
  logic [7:0]  cnt_hi_q, cnt_hi_d;
  logic [15:0] entries_q, entries_d;
  logic        err_q, err_d;

  logic        go;
  logic        unsup;
  logic        pad_done;
  logic [15:0] count_word;

  assign go         = accept_i && !err_q;
  assign unsup      = (byte_i >= MT_UNSUP_LO) && (byte_i <= MT_UNSUP_HI);
  assign pad_done   = pos_q == (is_pix_q ? PIX_PAD_LAST : ENC_PAD_LAST);
  assign count_word = {cnt_hi_q, byte_i};

  always_comb begin
    phase_d = phase_q;
    if (go) begin
      case (phase_q)
        PH_TYPE: begin
          if (byte_i == MT_PIXEL_FORMAT || byte_i == MT_SET_ENC) begin
            phase_d = PH_PAD;
          end else if (byte_i == MT_UPDATE_REQ) begin
            phase_d = PH_UPDATE;
          end
        end
        PH_PAD: begin
          if (pad_done) begin
            phase_d = is_pix_q ? PH_PIXEL : PH_COUNT;
          end
        end
        PH_PIXEL: begin
          if (pos_q == PIX_BODY_LAST) begin
            phase_d = PH_TYPE;
          end
        end
        PH_COUNT: begin
          if (pos_q != 4'd0) begin
            phase_d = (count_word == 16'd0) ? PH_TYPE : PH_ENC;
          end
        end
        PH_ENC: begin
          if (pos_q == ENC_ID_LAST && entries_q == 16'd1) begin
            phase_d = PH_TYPE;
          end
        end
        PH_UPDATE: begin
          if (pos_q == UPD_BODY_LAST) begin
            phase_d = PH_TYPE;
          end
        end
        default: begin
          phase_d = PH_TYPE;
        end
      endcase
    end
  end

  always_comb begin
    pos_d     = pos_q;
    is_pix_d  = is_pix_q;
    cnt_hi_d  = cnt_hi_q;
    entries_d = entries_q;
    err_d     = err_q;
    push_o    = 1'b0;
    op_o      = '{code: OP_PIX, pos: pos_q, last: 1'b0, eom: 1'b1, data: byte_i};
    if (go) begin
      case (phase_q)
        PH_TYPE: begin
          pos_d    = 4'd0;
          is_pix_d = byte_i == MT_PIXEL_FORMAT;
          if (byte_i != MT_PIXEL_FORMAT && byte_i != MT_SET_ENC && byte_i != MT_UPDATE_REQ) begin
            push_o    = 1'b1;
            op_o.code = unsup ? OP_UNSUP : OP_UNKNOWN;
            op_o.last = 1'b1;
            err_d     = 1'b1;
          end
        end
        PH_PAD: begin
          pos_d = pad_done ? 4'd0 : pos_q + 4'd1;
        end
        PH_PIXEL: begin
          push_o    = 1'b1;
          op_o.last = pos_q == PIX_BODY_LAST;
          pos_d     = pos_q + 4'd1;
        end
        PH_COUNT: begin
          if (pos_q == 4'd0) begin
            cnt_hi_d = byte_i;
            pos_d    = 4'd1;
          end else begin
            entries_d = count_word;
            pos_d     = 4'd0;
            if (count_word == 16'd0) begin
              push_o    = 1'b1;
              op_o.code = OP_EMPTY;
              op_o.last = 1'b1;
            end
          end
        end
        PH_ENC: begin
          push_o    = 1'b1;
          op_o.code = OP_ENC;
          op_o.last = pos_q == ENC_ID_LAST;
          op_o.eom  = entries_q == 16'd1;
          if (pos_q == ENC_ID_LAST) begin
            pos_d     = 4'd0;
            entries_d = entries_q - 16'd1;
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
        PH_UPDATE: begin
          push_o    = 1'b1;
          op_o.code = OP_UPD;
          op_o.last = pos_q == UPD_BODY_LAST;
          pos_d     = (pos_q == UPD_BODY_LAST) ? 4'd0 : pos_q + 4'd1;
        end
        default: begin
          pos_d = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TYPE;
      pos_q     <= 4'd0;
      is_pix_q  <= 1'b0;
      cnt_hi_q  <= 8'd0;
      entries_q <= 16'd0;
      err_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      is_pix_q  <= is_pix_d;
      cnt_hi_q  <= cnt_hi_d;
      entries_q <= entries_d;
      err_q     <= err_d;
    end
  end

endmodule

// ===== hdl/rcmp_fifo.sv =====
// Short queue of classified items between the front end and the back end.
// Register-based, one push and one pop per cycle.
// Depends on rcmp_pkg.
module rcmp_fifo import rcmp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  input  logic pop_i,
  output op_t  head_o,
  output logic empty_o,
  output logic full_o
);

  op_t            mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   cnt_q, cnt_d;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == QDEPTH[QAW:0];
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Item pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("Item popped from an empty queue.");

endmodule

// ===== hdl/rcmp_back.sv =====
// Back end of the parser: collects body bytes and encoding IDs and forms the results.
// Owns the output register of the master-side stream.
// Depends on rcmp_pkg.
module rcmp_back import rcmp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  op_t     head_i,
  input  logic    empty_i,
  output logic    pop_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output result_t out_o
);

  logic [7:0]  fb_q [16];
  logic [23:0] acc_q;
  logic        valid_q;
  result_t     res_q, res_d;
  logic        emit;

  assign pop_o       = !empty_i && (!head_i.last || !valid_q || out_ready_i);
  assign emit        = pop_o && head_i.last;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_comb begin
    res_d     = '0;
    res_d.eom = head_i.eom;
    case (head_i.code)
      OP_PIX: begin
        res_d.kind             = KIND_PIXEL_FORMAT;
        res_d.small_a          = fb_q[0];
        res_d.small_b          = fb_q[1];
        res_d.big_endian_flag  = fb_q[2];
        res_d.true_colour_flag = fb_q[3];
        res_d.word_a           = {fb_q[4], fb_q[5]};
        res_d.word_b           = {fb_q[6], fb_q[7]};
        res_d.word_c           = {fb_q[8], fb_q[9]};
        res_d.shift_triplet    = {fb_q[10], fb_q[11], fb_q[12]};
      end
      OP_UPD: begin
        res_d.kind    = KIND_UPDATE_REQ;
        res_d.small_a = fb_q[0];
        res_d.word_a  = {fb_q[1], fb_q[2]};
        res_d.word_b  = {fb_q[3], fb_q[4]};
        res_d.word_c  = {fb_q[5], fb_q[6]};
        res_d.word_d  = {fb_q[7], head_i.data};
      end
      OP_ENC: begin
        res_d.kind        = KIND_ENCODING;
        res_d.encoding_id = {acc_q, head_i.data};
      end
      OP_EMPTY: begin
        res_d.kind = KIND_EMPTY_ENC;
      end
      OP_UNSUP: begin
        res_d.kind = KIND_UNSUPPORTED;
      end
      default: begin
        res_d.kind = KIND_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.code == OP_PIX || head_i.code == OP_UPD)) begin
      fb_q[head_i.pos] <= head_i.data;
    end
    if (pop_o && head_i.code == OP_ENC) begin
      acc_q <= {acc_q[15:0], head_i.data};
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |=> valid_q)
    else $error("Finished item did not show up at the output.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (valid_q && !out_ready_i) |-> !emit)
    else $error("Pending result overwritten.");

endmodule

// ===== hdl/rfb_client_message_parser_top.sv =====
// A result passes through the queue and the output register of the back end before it is offered.
// Throughput: one byte per cycle while the queue is not full; while a result waits, bytes keep
// flowing until the item of the next completing byte and one more item fill the two-entry queue.
// Reset is asynchronous and active low; it returns the parser to awaiting a message type,
// clears the error latch and empties the queue. A latched error holds until reset.
module rfb_client_message_parser_top import rcmp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte[7:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [151:0] m_axis_tdata_o,   // small_a, small_b, big_endian_flag,
                                         // true_colour_flag, word_a, word_b, word_c,
                                         // word_d, shift_triplet, encoding_id
  output logic         m_axis_tlast_o,   // end_of_message
  output logic [2:0]   m_axis_tuser_o    // msg_kind
);

  logic    accept;
  logic    push;
  op_t     push_op;
  logic    pop;
  op_t     head;
  logic    empty;
  logic    full;
  result_t res;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  rcmp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .push_o   (push),
    .op_o     (push_op)
  );

  rcmp_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (empty),
    .full_o    (full)
  );

  rcmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_o       (res)
  );

  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.eom;
  assign m_axis_tdata_o = {res.encoding_id, res.shift_triplet, res.word_d, res.word_c,
                           res.word_b, res.word_a, res.true_colour_flag,
                           res.big_endian_flag, res.small_b, res.small_a};

endmodule

// ===== tb/rfb_client_message_parser_top_tb.sv =====
// Self-checking testbench of the RFB client message parser: streams message bytes in,
// predicts every decoded result and compares it field by field with the output stream.
// Depends on rcmp_pkg and rfb_client_message_parser_top.
module rfb_client_message_parser_top_tb;
  import rcmp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_PAD_BYTES  = 3;
  localparam int ENC_PAD_BYTES  = 1;
  localparam int PIX_BODY_BYTES = 16;
  localparam int UPD_BODY_BYTES = 9;
  localparam int ENC_ID_BYTES   = 4;
  localparam int RANDOM_BYTES   = 1150;

  localparam int FILL_ZERO = 0;
  localparam int FILL_ONES = 1;
  localparam int FILL_RAND = 2;

  typedef struct {
    logic [7:0] data;
    bit         drain;
  } stream_byte_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata = 8'd0;
  logic         m_tready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [151:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic [2:0]   m_axis_tuser_o;

  rfb_client_message_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  stream_byte_t tx_bytes[$];
  result_t      expected_msgs[$];
  int           n_errors = 0;
  int           n_queued = 0;
  int           n_accepted = 0;
  int           n_checked = 0;
  int           kind_seen[8];

  // Parser shadow state.
  phase_e      ps_phase = PH_TYPE;
  logic [7:0]  ps_type = 8'd0;
  int          ps_pos = 0;
  logic [7:0]  ps_bytes[16];
  logic [15:0] ps_left = 16'd0;
  logic [31:0] ps_id = 32'd0;
  bit          ps_err = 1'b0;

  function automatic void parse_byte(input logic [7:0] b, output bit hit, output result_t r);
    hit = 1'b0;
    r = '0;
    if (ps_err) return;
    case (ps_phase)
      PH_TYPE: begin
        ps_type = b;
        ps_pos = 0;
        if (b == MT_PIXEL_FORMAT || b == MT_SET_ENC) begin
          ps_phase = PH_PAD;
        end else if (b == MT_UPDATE_REQ) begin
          ps_phase = PH_UPDATE;
        end else begin
          hit = 1'b1;
          r.kind = (b >= MT_UNSUP_LO && b <= MT_UNSUP_HI) ? KIND_UNSUPPORTED : KIND_UNKNOWN;
          r.eom = 1'b1;
          ps_err = 1'b1;
        end
      end
      PH_PAD: begin
        ps_pos++;
        if (ps_pos >= ((ps_type == MT_PIXEL_FORMAT) ? PIX_PAD_BYTES : ENC_PAD_BYTES)) begin
          ps_pos = 0;
          ps_phase = (ps_type == MT_PIXEL_FORMAT) ? PH_PIXEL : PH_COUNT;
        end
      end
      PH_PIXEL: begin
        ps_bytes[ps_pos] = b;
        ps_pos++;
        if (ps_pos == PIX_BODY_BYTES) begin
          hit = 1'b1;
          r.kind = KIND_PIXEL_FORMAT;
          r.eom = 1'b1;
          r.small_a = ps_bytes[0];
          r.small_b = ps_bytes[1];
          r.big_endian_flag = ps_bytes[2];
          r.true_colour_flag = ps_bytes[3];
          r.word_a = {ps_bytes[4], ps_bytes[5]};
          r.word_b = {ps_bytes[6], ps_bytes[7]};
          r.word_c = {ps_bytes[8], ps_bytes[9]};
          r.shift_triplet = {ps_bytes[10], ps_bytes[11], ps_bytes[12]};
          ps_pos = 0;
          ps_phase = PH_TYPE;
        end
      end
      PH_COUNT: begin
        ps_bytes[ps_pos] = b;
        ps_pos++;
        if (ps_pos == 2) begin
          ps_left = {ps_bytes[0], ps_bytes[1]};
          ps_pos = 0;
          ps_id = 32'd0;
          if (ps_left == 16'd0) begin
            hit = 1'b1;
            r.kind = KIND_EMPTY_ENC;
            r.eom = 1'b1;
            ps_phase = PH_TYPE;
          end else begin
            ps_phase = PH_ENC;
          end
        end
      end
      PH_ENC: begin
        ps_id = {ps_id[23:0], b};
        ps_pos++;
        if (ps_pos == ENC_ID_BYTES) begin
          ps_left = ps_left - 16'd1;
          hit = 1'b1;
          r.kind = KIND_ENCODING;
          r.eom = (ps_left == 16'd0);
          r.encoding_id = ps_id;
          ps_id = 32'd0;
          ps_pos = 0;
          if (ps_left == 16'd0) ps_phase = PH_TYPE;
        end
      end
      PH_UPDATE: begin
        ps_bytes[ps_pos] = b;
        ps_pos++;
        if (ps_pos == UPD_BODY_BYTES) begin
          hit = 1'b1;
          r.kind = KIND_UPDATE_REQ;
          r.eom = 1'b1;
          r.small_a = ps_bytes[0];
          r.word_a = {ps_bytes[1], ps_bytes[2]};
          r.word_b = {ps_bytes[3], ps_bytes[4]};
          r.word_c = {ps_bytes[5], ps_bytes[6]};
          r.word_d = {ps_bytes[7], ps_bytes[8]};
          ps_pos = 0;
          ps_phase = PH_TYPE;
        end
      end
      default: begin
        ps_phase = PH_TYPE;
        ps_pos = 0;
      end
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int           burst_left = 0;
  int           gap_left = 0;
  bit           tx_busy;
  bit           tx_hit;
  result_t      tx_res;
  logic         nxt_valid;
  logic [7:0]   nxt_data;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        parse_byte(s_tdata, tx_hit, tx_res);
        if (tx_hit) expected_msgs.push_back(tx_res);
        void'(tx_bytes.pop_front());
        n_accepted++;
      end
      tx_busy = s_tvalid && !s_axis_tready_o;
      if (!tx_busy) begin
        nxt_valid = 1'b0;
        nxt_data = s_tdata;
        if (gap_left > 0) begin
          gap_left--;
        end else if (tx_bytes.size() > 0 &&
                     !(tx_bytes[0].drain && expected_msgs.size() != 0)) begin
          nxt_valid = 1'b1;
          nxt_data = tx_bytes[0].data;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        s_tvalid <= nxt_valid;
        s_tdata <= nxt_data;
      end
    end
  end

  // Receiver: stall pattern that switches between modes of random length.
  int   rx_mode = 0;
  int   rx_left = 0;
  logic nxt_ready;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(4, 40);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       nxt_ready = 1'b1;
      1:       nxt_ready = 1'($urandom_range(0, 1));
      2:       nxt_ready = ($urandom_range(0, 3) == 0);
      default: nxt_ready = 1'b0;
    endcase
    m_tready <= nxt_ready;
  end

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      n_errors++;
    end
  endfunction

  result_t exp_msg;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (expected_msgs.size() == 0) begin
        $error("msg_kind: expected no result, got %0d", m_axis_tuser_o);
        n_errors++;
      end else begin
        exp_msg = expected_msgs.pop_front();
        check_field("msg_kind", 32'(exp_msg.kind), 32'(m_axis_tuser_o));
        check_field("end_of_message", 32'(exp_msg.eom), 32'(m_axis_tlast_o));
        check_field("small_a", 32'(exp_msg.small_a), 32'(m_axis_tdata_o[7:0]));
        check_field("small_b", 32'(exp_msg.small_b), 32'(m_axis_tdata_o[15:8]));
        check_field("big_endian_flag", 32'(exp_msg.big_endian_flag),
                    32'(m_axis_tdata_o[23:16]));
        check_field("true_colour_flag", 32'(exp_msg.true_colour_flag),
                    32'(m_axis_tdata_o[31:24]));
        check_field("word_a", 32'(exp_msg.word_a), 32'(m_axis_tdata_o[47:32]));
        check_field("word_b", 32'(exp_msg.word_b), 32'(m_axis_tdata_o[63:48]));
        check_field("word_c", 32'(exp_msg.word_c), 32'(m_axis_tdata_o[79:64]));
        check_field("word_d", 32'(exp_msg.word_d), 32'(m_axis_tdata_o[95:80]));
        check_field("shift_triplet", 32'(exp_msg.shift_triplet),
                    32'(m_axis_tdata_o[119:96]));
        check_field("encoding_id", exp_msg.encoding_id, m_axis_tdata_o[151:120]);
        kind_seen[exp_msg.kind]++;
        n_checked++;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input bit drain = 1'b0);
    stream_byte_t sb;
    sb.data = b;
    sb.drain = drain;
    tx_bytes.push_back(sb);
    n_queued++;
  endtask

  function automatic logic [7:0] content_byte(input int style);
    case (style)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_style();
    int r;
    r = $urandom_range(0, 7);
    return (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RAND;
  endfunction

  task automatic queue_pixel_format(input int style, input bit drain);
    queue_byte(MT_PIXEL_FORMAT, drain);
    repeat (PIX_PAD_BYTES) queue_byte(content_byte(FILL_RAND));
    repeat (PIX_BODY_BYTES) queue_byte(content_byte(style));
  endtask

  task automatic queue_update(input int style, input bit drain);
    queue_byte(MT_UPDATE_REQ, drain);
    repeat (UPD_BODY_BYTES) queue_byte(content_byte(style));
  endtask

  task automatic queue_encodings(input logic [15:0] count, input int style, input bit drain);
    queue_byte(MT_SET_ENC, drain);
    repeat (ENC_PAD_BYTES) queue_byte(content_byte(FILL_RAND));
    queue_byte(count[15:8]);
    queue_byte(count[7:0]);
    repeat (int'(count) * ENC_ID_BYTES) queue_byte(content_byte(style));
  endtask

  initial begin
    int         sel;
    bit         drain;
    logic [7:0] bad_type;

    queue_update(FILL_ONES, 1'b0);
    queue_encodings(16'd0, FILL_RAND, 1'b0);
    queue_encodings(16'd1, FILL_ONES, 1'b0);
    queue_byte(MT_SET_ENC);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'h01);
    queue_byte(8'h80);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'h01);

    queue_encodings(16'h0100 + 16'($urandom_range(0, 3)), FILL_RAND, 1'b0);
    while (n_queued < RANDOM_BYTES) begin
      sel = $urandom_range(0, 9);
      drain = ($urandom_range(0, 19) == 0);
      if (sel < 3) begin
        queue_pixel_format(pick_style(), drain);
      end else if (sel < 6) begin
        queue_update(pick_style(), drain);
      end else begin
        queue_encodings(($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40))
                                                    : 16'($urandom_range(0, 6)),
                        pick_style(), drain);
      end
    end

    // A bad type latches the error, so it can only come last; the bytes after it are ignored.
    if ($urandom_range(0, 1) == 0) begin
      bad_type = 8'($urandom_range(MT_UNSUP_LO, MT_UNSUP_HI));
    end else begin
      bad_type = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'($urandom_range(7, 255));
    end
    queue_byte(bad_type, 1'b1);
    repeat (6) queue_byte(content_byte(FILL_RAND));
    queue_update(FILL_RAND, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (tx_bytes.size() != 0) @(posedge clk_i);
    while (expected_msgs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Streamed %0d bytes and checked %0d results: %0d pixel formats, %0d entries,",
             n_accepted, n_checked, kind_seen[KIND_PIXEL_FORMAT], kind_seen[KIND_ENCODING]);
    $display("%0d empty encoding lists, %0d update requests and %0d type errors.",
             kind_seen[KIND_EMPTY_ENC], kind_seen[KIND_UPDATE_REQ],
             kind_seen[KIND_UNKNOWN] + kind_seen[KIND_UNSUPPORTED]);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== rfb_client_message_parser_top.f =====
hdl/rcmp_pkg.sv
hdl/rcmp_front.sv
hdl/rcmp_fifo.sv
hdl/rcmp_back.sv
hdl/rfb_client_message_parser_top.sv
tb/rfb_client_message_parser_top_tb.sv
